>>> hdl/capture_frequency_duty_meter_top_assert.svh
// assertion macros for the capture frequency / duty meter checker
// no dependencies; included by the checker file
`ifndef CAPTURE_FREQUENCY_DUTY_METER_TOP_ASSERT_SVH
`define CAPTURE_FREQUENCY_DUTY_METER_TOP_ASSERT_SVH

// same-cycle implication
`define CFDM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfdm assertion failed");

// next-cycle implication
`define CFDM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfdm assertion failed");

`endif

>>> hdl/cfdm_pkg.sv
// shared types, constants and helpers of the capture frequency / duty meter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cfdm_pkg;

   localparam int NUM_CHANNELS = 5;
   localparam int COUNTER_BITS = 16;

   localparam int CH_W   = 3;
   localparam int CAP_W  = 16;
   localparam int TICK_W = 27;
   localparam int MODE_W = 5;
   localparam int DUTY_W = 16;

   localparam int CNT_W  = COUNTER_BITS;
   localparam int IVL_W  = CNT_W + 1;
   localparam int NUM_W  = (TICK_W > IVL_W + DUTY_W) ? TICK_W : IVL_W + DUTY_W;
   localparam int DEN_W  = IVL_W + 1;
   localparam int STEP_W = $clog2(NUM_W + 1);
   localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   localparam logic [CH_W:0] NUM_CH_LIMIT = (CH_W + 1)'(NUM_CHANNELS);

   localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(1000000);
   localparam logic [MODE_W-1:0] MODE_RESET = MODE_W'(24);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      CSR_TICK_RATE = 1'b0,
      CSR_DUTY_MASK = 1'b1
   } csr_index_type;

   typedef logic [1:0] phase_type;
   localparam phase_type PH_WAIT  = 2'd0;
   localparam phase_type PH_FIRST = 2'd1;
   localparam phase_type PH_HIGH  = 2'd2;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_DELIVER
   } back_state_type;

   // one classified event on its way to the back end
   typedef struct packed {
      logic [CH_W-1:0]  channel;
      logic             done;
      logic             is_duty;
      logic             next_falling;
      logic [NUM_W-1:0] dividend;
      logic [DEN_W-1:0] divisor;
   } cmd_type;

   // interval modulo the counter size, zero meaning a full wrap
   function automatic logic [IVL_W-1:0] interval_f(input logic [CNT_W-1:0] a,
                                                    input logic [CNT_W-1:0] b);
      logic [CNT_W-1:0] d;
      d = b - a;
      return (d == '0) ? {1'b1, {CNT_W{1'b0}}} : {1'b0, d};
   endfunction

endpackage

`default_nettype wire

>>> hdl/cfdm_queue.sv
// two-entry command queue between front and back end
// depends on cfdm_pkg
`timescale 1ns / 1ps
`default_nettype none

module cfdm_queue (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  wire cfdm_pkg::cmd_type push_data,
   output logic             full,
   input  wire              pop,
   output cfdm_pkg::cmd_type head,
   output logic             empty
);
   import cfdm_pkg::*;

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> hdl/cfdm_front.sv
// front end: config registers, per-channel capture state, event classification
// depends on cfdm_pkg; feeds cfdm_queue
`timescale 1ns / 1ps
`default_nettype none

module cfdm_front (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire  [cfdm_pkg::CH_W-1:0]   req_channel_index,
   input  wire  [cfdm_pkg::CAP_W-1:0]  req_capture_value,
   input  wire                         csr_write_en,
   input  wire                         csr_index,
   input  wire  [cfdm_pkg::TICK_W-1:0] csr_wdata,
   input  wire                         q_full,
   output logic                        q_push,
   output cfdm_pkg::cmd_type           q_data
);
   import cfdm_pkg::*;

   logic [TICK_W-1:0] tick_ff;
   logic [MODE_W-1:0] mode_ff;

   phase_type         phase_ff  [NUM_CHANNELS];
   logic [CNT_W-1:0]  first_ff  [NUM_CHANNELS];
   logic [CNT_W-1:0]  second_ff [NUM_CHANNELS];
   logic [IVL_W-1:0]  high_ff   [NUM_CHANNELS];

   logic [CH_IDX_W-1:0] idx;
   logic [CNT_W-1:0]    cap;
   logic                ch_ok, dm, accept;
   phase_type           ph;
   logic [IVL_W-1:0]    ivl_first, ivl_second;

   phase_type           phase_in;
   logic [CNT_W-1:0]    first_in, second_in;
   logic [IVL_W-1:0]    high_in;
   logic                first_we, second_we, high_we;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept;

   assign ch_ok = ({1'b0, req_channel_index} < NUM_CH_LIMIT);
   assign idx   = CH_IDX_W'(req_channel_index);
   assign cap   = CNT_W'(req_capture_value);
   assign dm    = ch_ok && mode_ff[req_channel_index];
   assign ph    = phase_ff[idx];

   assign ivl_first  = interval_f(first_ff[idx], cap);
   assign ivl_second = interval_f(second_ff[idx], cap);

   always_comb begin
      phase_in  = PH_WAIT;
      first_in  = cap;
      second_in = cap;
      high_in   = ivl_first;
      first_we  = 1'b0;
      second_we = 1'b0;
      high_we   = 1'b0;
      q_data    = '0;
      q_data.channel = req_channel_index;
      q_data.is_duty = dm;
      if (ch_ok) begin
         if (!dm) begin
            if (ph == PH_FIRST) begin
               second_we        = 1'b1;
               q_data.done      = 1'b1;
               q_data.dividend  = NUM_W'(tick_ff);
               q_data.divisor   = DEN_W'(ivl_first);
               phase_in         = PH_WAIT;
            end else begin
               first_we = 1'b1;
               phase_in = PH_FIRST;
            end
         end else begin
            if (ph == PH_FIRST) begin
               second_we = 1'b1;
               high_we   = 1'b1;
               phase_in  = PH_HIGH;
            end else if (ph == PH_HIGH) begin
               first_we         = 1'b1;
               q_data.done      = 1'b1;
               q_data.dividend  = NUM_W'({high_ff[idx], {DUTY_W{1'b0}}});
               q_data.divisor   = DEN_W'(high_ff[idx]) + DEN_W'(ivl_second);
               phase_in         = PH_WAIT;
            end else begin
               first_we            = 1'b1;
               q_data.next_falling = 1'b1;
               phase_in            = PH_FIRST;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= TICK_RESET;
         mode_ff <= MODE_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_TICK_RATE: tick_ff <= csr_wdata;
            CSR_DUTY_MASK: mode_ff <= csr_wdata[MODE_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            phase_ff[i]  <= PH_WAIT;
            first_ff[i]  <= '0;
            second_ff[i] <= '0;
            high_ff[i]   <= '0;
         end
      end else if (accept && ch_ok) begin
         phase_ff[idx] <= phase_in;
         if (first_we) begin
            first_ff[idx] <= first_in;
         end
         if (second_we) begin
            second_ff[idx] <= second_in;
         end
         if (high_we) begin
            high_ff[idx] <= high_in;
         end
      end
   end

endmodule

`default_nettype wire

>>> hdl/cfdm_back.sv
// back end: shared restoring divider and result register
// depends on cfdm_pkg; drains cfdm_queue
`timescale 1ns / 1ps
`default_nettype none

module cfdm_back (
   input  wire                         clock,
   input  wire                         reset,
   input  wire cfdm_pkg::cmd_type      q_head,
   input  wire                         q_empty,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output logic [cfdm_pkg::CH_W-1:0]   rsp_result_channel,
   output logic                        rsp_measurement_done,
   output logic                        rsp_is_duty,
   output logic [cfdm_pkg::TICK_W-1:0] rsp_frequency_hz,
   output logic [cfdm_pkg::DUTY_W-1:0] rsp_duty_fraction,
   output logic                        rsp_next_edge_falling
);
   import cfdm_pkg::*;

   back_state_type state_ff, state_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]    chan_ff;
   logic               done_ff, duty_ff, nfall_ff;
   logic [TICK_W-1:0]  freq_ff;
   logic [DUTY_W-1:0]  frac_ff;

   logic [CH_W-1:0]    meta_chan_ff;
   logic               meta_duty_ff;
   logic [NUM_W-1:0]   quo_ff, quo_in;
   logic [DEN_W-1:0]   rem_ff, rem_in;
   logic [DEN_W-1:0]   den_ff;
   logic [STEP_W-1:0]  step_ff, step_in;

   logic [DEN_W:0]     trial;
   logic               fits;
   logic               rsp_free, start_div, do_step, write_rsp, from_div;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty && q_head.done) begin
               state_in = BK_DIVIDE;
            end
         end
         BK_DIVIDE: begin
            if (step_ff == STEP_W'(1)) begin
               state_in = BK_DELIVER;
            end
         end
         BK_DELIVER: begin
            if (rsp_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop     = 1'b0;
      start_div = 1'b0;
      do_step   = 1'b0;
      write_rsp = 1'b0;
      from_div  = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               if (q_head.done) begin
                  q_pop     = 1'b1;
                  start_div = 1'b1;
               end else if (rsp_free) begin
                  q_pop     = 1'b1;
                  write_rsp = 1'b1;
               end
            end
         end
         BK_DIVIDE: do_step = 1'b1;
         BK_DELIVER: begin
            write_rsp = rsp_free;
            from_div  = 1'b1;
         end
         default: ;
      endcase
   end

   // one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      if (start_div) begin
         quo_in  = q_head.dividend;
         rem_in  = '0;
         step_in = STEP_W'(NUM_W);
      end else if (do_step) begin
         quo_in  = {quo_ff[NUM_W-2:0], fits};
         rem_in  = fits ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         step_in = step_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (write_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      if (start_div) begin
         den_ff       <= q_head.divisor;
         meta_chan_ff <= q_head.channel;
         meta_duty_ff <= q_head.is_duty;
      end
   end

   always_ff @(posedge clock) begin
      if (write_rsp) begin
         if (from_div) begin
            chan_ff  <= meta_chan_ff;
            done_ff  <= 1'b1;
            duty_ff  <= meta_duty_ff;
            nfall_ff <= 1'b0;
            freq_ff  <= meta_duty_ff ? '0 : quo_ff[TICK_W-1:0];
            frac_ff  <= meta_duty_ff ? quo_ff[DUTY_W-1:0] : '0;
         end else begin
            chan_ff  <= q_head.channel;
            done_ff  <= 1'b0;
            duty_ff  <= q_head.is_duty;
            nfall_ff <= q_head.next_falling;
            freq_ff  <= '0;
            frac_ff  <= '0;
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_result_channel    = chan_ff;
   assign rsp_measurement_done  = done_ff;
   assign rsp_is_duty           = duty_ff;
   assign rsp_frequency_hz      = freq_ff;
   assign rsp_duty_fraction     = frac_ff;
   assign rsp_next_edge_falling = nfall_ff;

endmodule

`default_nettype wire

>>> hdl/capture_frequency_duty_meter_top.sv
// top level of the capture frequency / duty meter: front end, queue, back end
// depends on cfdm_pkg, cfdm_front, cfdm_queue, cfdm_back
//
//  port group  direction  beat contents
//  req_        in         channel index, 16-bit captured counter value
//  rsp_        out        channel, done, mode, frequency, duty fraction, next polarity
//  csr_        in         write enable, register index, write data
//
//  an event that completes no measurement passes the queue and then the rsp register
//  a completed measurement goes through 33 divider steps, one per quotient bit
//  the front end keeps taking beats until the two-entry queue is full
//  synchronous reset clears config to defaults, all channel state to zero
//  a stalled rsp beat holds; the divider result waits in the back end
`timescale 1ns / 1ps
`default_nettype none

module capture_frequency_duty_meter_top (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire  [cfdm_pkg::CH_W-1:0]   req_channel_index,
   input  wire  [cfdm_pkg::CAP_W-1:0]  req_capture_value,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output logic [cfdm_pkg::CH_W-1:0]   rsp_result_channel,
   output logic                        rsp_measurement_done,
   output logic                        rsp_is_duty,
   output logic [cfdm_pkg::TICK_W-1:0] rsp_frequency_hz,
   output logic [cfdm_pkg::DUTY_W-1:0] rsp_duty_fraction,
   output logic                        rsp_next_edge_falling,
   input  wire                         csr_write_en,
   input  wire                         csr_index,
   input  wire  [cfdm_pkg::TICK_W-1:0] csr_wdata
);
   import cfdm_pkg::*;

   cmd_type push_data, head;
   logic    push, pop, full, empty;

   cfdm_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_channel_index (req_channel_index),
      .req_capture_value (req_capture_value),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .q_full            (full),
      .q_push            (push),
      .q_data            (push_data)
   );

   cfdm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .head      (head),
      .empty     (empty)
   );

   cfdm_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_head                (head),
      .q_empty               (empty),
      .q_pop                 (pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_result_channel    (rsp_result_channel),
      .rsp_measurement_done  (rsp_measurement_done),
      .rsp_is_duty           (rsp_is_duty),
      .rsp_frequency_hz      (rsp_frequency_hz),
      .rsp_duty_fraction     (rsp_duty_fraction),
      .rsp_next_edge_falling (rsp_next_edge_falling)
   );

endmodule

`default_nettype wire

>>> hdl/cfdm_checker.sv
// port-level checks on the result channel of the meter, bound to the top level
// depends on cfdm_pkg and capture_frequency_duty_meter_top_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "capture_frequency_duty_meter_top_assert.svh"

module cfdm_checker (
   input wire                         clock,
   input wire                         reset,
   input wire                         rsp_valid,
   input wire                         rsp_ready,
   input wire [cfdm_pkg::CH_W-1:0]    rsp_result_channel,
   input wire                         rsp_measurement_done,
   input wire                         rsp_is_duty,
   input wire [cfdm_pkg::TICK_W-1:0]  rsp_frequency_hz,
   input wire [cfdm_pkg::DUTY_W-1:0]  rsp_duty_fraction,
   input wire                         rsp_next_edge_falling
);
   import cfdm_pkg::*;

   // stalled beat holds
   `CFDM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_channel) && $stable(rsp_frequency_hz) && $stable(rsp_duty_fraction))

   // values only come with a completed measurement, and only in the matching field
   `CFDM_ASSERT_NOW(a_value_field, clock, reset, rsp_valid, (rsp_measurement_done || (rsp_frequency_hz == '0 && rsp_duty_fraction == '0)) && (!rsp_is_duty || rsp_frequency_hz == '0) && (rsp_is_duty || rsp_duty_fraction == '0))

   // falling edge armed only after the first rising edge of a duty channel
   `CFDM_ASSERT_NOW(a_next_falling, clock, reset, rsp_valid && rsp_next_edge_falling, rsp_is_duty && !rsp_measurement_done)

   // out-of-range channels give an empty result
   `CFDM_ASSERT_NOW(a_bad_channel, clock, reset, rsp_valid && ({1'b0, rsp_result_channel} >= NUM_CH_LIMIT), !rsp_measurement_done && !rsp_is_duty && !rsp_next_edge_falling)

endmodule

bind capture_frequency_duty_meter_top cfdm_checker u_checker (.*);

`default_nettype wire

>>> tb/tb_top.sv
// testbench for capture_frequency_duty_meter_top: drives capture beats and config writes,
// predicts every result beat per channel and checks it field by field
// depends on cfdm_pkg and the capture_frequency_duty_meter_top rtl
`timescale 1ns / 1ps

module tb_top;
   import cfdm_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int BURSTS      = 8;
   localparam int BURST_ITEMS = 100;

   typedef struct {
      logic [CH_W-1:0]   channel;
      logic              done;
      logic              is_duty;
      logic [TICK_W-1:0] frequency;
      logic [DUTY_W-1:0] duty;
      logic              next_falling;
   } meter_result_type;

   class meter_scoreboard;
      logic [TICK_W-1:0] tick_rate;
      logic [MODE_W-1:0] duty_mask;
      phase_type         phase [NUM_CHANNELS];
      logic [CAP_W-1:0]  first_cap [NUM_CHANNELS];
      logic [CAP_W-1:0]  second_cap [NUM_CHANNELS];
      logic [CAP_W:0]    high_ticks [NUM_CHANNELS];
      meter_result_type  expected_results [$];
      int unsigned       errors;

      function new();
         tick_rate = TICK_RESET;
         duty_mask = MODE_RESET;
         errors = 0;
         foreach (phase[i]) begin
            phase[i] = PH_WAIT;
            first_cap[i] = '0;
            second_cap[i] = '0;
            high_ticks[i] = '0;
         end
      endfunction

      function void write_reg(csr_index_type idx, logic [TICK_W-1:0] value);
         case (idx)
            CSR_TICK_RATE: tick_rate = value;
            CSR_DUTY_MASK: duty_mask = value[MODE_W-1:0];
            default: ;
         endcase
      endfunction

      // counter ticks from a to b, a zero span being a full counter wrap
      function logic [CAP_W:0] ticks_between(logic [CAP_W-1:0] a, logic [CAP_W-1:0] b);
         logic [CAP_W-1:0] d;
         d = b - a;
         if (d == '0) return (CAP_W+1)'(1) << CAP_W;
         return {1'b0, d};
      endfunction

      function void take_capture(logic [CH_W-1:0] ch, logic [CAP_W-1:0] cap);
         meter_result_type r;
         logic [CAP_W:0]   low;
         logic [63:0]      scaled;
         r.channel = ch;
         r.done = 1'b0;
         r.is_duty = 1'b0;
         r.frequency = '0;
         r.duty = '0;
         r.next_falling = 1'b0;
         if (ch < NUM_CHANNELS) begin
            r.is_duty = duty_mask[ch];
            if (!r.is_duty) begin
               if (phase[ch] == PH_FIRST) begin
                  second_cap[ch] = cap;
                  r.frequency = tick_rate / ticks_between(first_cap[ch], cap);
                  r.done = 1'b1;
                  phase[ch] = PH_WAIT;
               end else begin
                  first_cap[ch] = cap;
                  phase[ch] = PH_FIRST;
               end
            end else if (phase[ch] == PH_FIRST) begin
               second_cap[ch] = cap;
               high_ticks[ch] = ticks_between(first_cap[ch], cap);
               phase[ch] = PH_HIGH;
            end else if (phase[ch] == PH_HIGH) begin
               first_cap[ch] = cap;
               low = ticks_between(second_cap[ch], cap);
               scaled = {31'b0, high_ticks[ch], 16'b0};
               scaled = scaled / (64'(high_ticks[ch]) + 64'(low));
               r.duty = scaled[DUTY_W-1:0];
               r.done = 1'b1;
               phase[ch] = PH_WAIT;
            end else begin
               first_cap[ch] = cap;
               phase[ch] = PH_FIRST;
               r.next_falling = 1'b1;
            end
         end
         expected_results.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(meter_result_type got);
         meter_result_type want;
         if (expected_results.size() == 0) begin
            $error("unexpected result beat on channel %0d", got.channel);
            errors++;
            return;
         end
         want = expected_results.pop_front();
         compare_field("result_channel", 32'(want.channel), 32'(got.channel));
         compare_field("measurement_done", 32'(want.done), 32'(got.done));
         compare_field("is_duty", 32'(want.is_duty), 32'(got.is_duty));
         compare_field("frequency_hz", 32'(want.frequency), 32'(got.frequency));
         compare_field("duty_fraction", 32'(want.duty), 32'(got.duty));
         compare_field("next_edge_falling", 32'(want.next_falling), 32'(got.next_falling));
      endfunction

      function int unsigned pending();
         return expected_results.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   wire                 req_ready;
   logic [CH_W-1:0]     req_channel_index = '0;
   logic [CAP_W-1:0]    req_capture_value = '0;
   wire                 rsp_valid;
   logic                rsp_ready = 1'b0;
   wire  [CH_W-1:0]     rsp_result_channel;
   wire                 rsp_measurement_done;
   wire                 rsp_is_duty;
   wire  [TICK_W-1:0]   rsp_frequency_hz;
   wire  [DUTY_W-1:0]   rsp_duty_fraction;
   wire                 rsp_next_edge_falling;
   logic                csr_write_en = 1'b0;
   csr_index_type       csr_index = CSR_TICK_RATE;
   logic [TICK_W-1:0]   csr_wdata = '0;

   meter_scoreboard     meter;
   meter_result_type    rsp_beat;
   bit                  req_idle = 1'b1;
   bit                  rsp_idle = 1'b1;
   int unsigned         rsp_hold = 0;
   int unsigned         quiet_cycles = 0;
   logic [CAP_W-1:0]    last_cap [8];

   capture_frequency_duty_meter_top u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_channel_index     (req_channel_index),
      .req_capture_value     (req_capture_value),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_result_channel    (rsp_result_channel),
      .rsp_measurement_done  (rsp_measurement_done),
      .rsp_is_duty           (rsp_is_duty),
      .rsp_frequency_hz      (rsp_frequency_hz),
      .rsp_duty_fraction     (rsp_duty_fraction),
      .rsp_next_edge_falling (rsp_next_edge_falling),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_valid && rsp_ready) begin
         rsp_beat.channel = rsp_result_channel;
         rsp_beat.done = rsp_measurement_done;
         rsp_beat.is_duty = rsp_is_duty;
         rsp_beat.frequency = rsp_frequency_hz;
         rsp_beat.duty = rsp_duty_fraction;
         rsp_beat.next_falling = rsp_next_edge_falling;
         meter.check_result(rsp_beat);
         rsp_hold = rsp_idle ? $urandom_range(0, 15) : 0;
         rsp_ready <= (rsp_hold == 0);
      end else if (rsp_hold != 0) begin
         rsp_hold--;
         rsp_ready <= (rsp_hold == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   task automatic send_capture(input logic [CH_W-1:0] ch, input logic [CAP_W-1:0] cap);
      int unsigned gap;
      gap = req_idle ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_channel_index <= ch;
      req_capture_value <= cap;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      meter.take_capture(ch, cap);
      last_cap[ch] = cap;
   endtask

   // mostly in-range channels, each advancing from its own last capture
   task automatic send_random_capture();
      logic [CH_W-1:0]  ch;
      logic [CAP_W-1:0] span;
      if ($urandom_range(0, 19) < 2)
         ch = CH_W'($urandom_range(NUM_CHANNELS, 7));
      else
         ch = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
      case ($urandom_range(0, 9))
         0: span = '0;
         1: span = CAP_W'(1);
         2, 3: span = CAP_W'($urandom_range(1, 255));
         default: span = CAP_W'($urandom_range(1, 65535));
      endcase
      send_capture(ch, last_cap[ch] + span);
   endtask

   task automatic write_config(input logic [TICK_W-1:0] tick, input logic [MODE_W-1:0] mask);
      csr_write_en <= 1'b1;
      csr_index <= CSR_TICK_RATE;
      csr_wdata <= tick;
      @(posedge clock);
      csr_index <= CSR_DUTY_MASK;
      csr_wdata <= TICK_W'(mask);
      @(posedge clock);
      csr_write_en <= 1'b0;
      meter.write_reg(CSR_TICK_RATE, tick);
      meter.write_reg(CSR_DUTY_MASK, TICK_W'(mask));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (meter.pending() != 0) @(posedge clock);
   endtask

   initial begin
      logic [TICK_W-1:0] tick;
      logic [MODE_W-1:0] mask;
      meter = new();
      foreach (last_cap[i]) last_cap[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset config: channels 0..2 period, 3..4 duty
      send_capture(3'd0, 16'd0);
      send_capture(3'd0, 16'hffff);
      send_capture(3'd0, 16'hffff);
      send_capture(3'd0, 16'hffff);
      send_capture(3'd1, 16'hffff);
      send_capture(3'd1, 16'd0);
      send_capture(3'd3, 16'd0);
      send_capture(3'd3, 16'd16384);
      send_capture(3'd3, 16'hffff);
      send_capture(3'd4, 16'hffff);
      send_capture(3'd4, 16'hffff);
      send_capture(3'd4, 16'hffff);
      send_capture(3'd5, 16'h5555);
      send_capture(3'd6, 16'haaaa);
      send_capture(3'd7, 16'hffff);
      send_capture(3'd3, 16'd1000);
      send_capture(3'd3, 16'd2000);
      send_capture(3'd2, 16'd100);
      drain_results();

      // zero tick rate; channel 3 left mid duty measurement now in period mode
      write_config('0, '0);
      send_capture(3'd3, 16'd5000);
      send_capture(3'd3, 16'd6000);
      drain_results();

      // channel 2 left mid period measurement carries on in duty mode
      write_config(TICK_W'(100000000), 5'b11100);
      send_capture(3'd2, 16'd100);
      send_capture(3'd2, 16'd101);
      send_capture(3'd0, 16'd7);
      send_capture(3'd0, 16'd8);
      send_capture(3'd4, 16'd7);
      send_capture(3'd4, 16'd8);
      send_capture(3'd4, 16'd8);
      drain_results();

      for (int b = 0; b < BURSTS; b++) begin
         case (b)
            0: begin tick = TICK_W'(1); mask = '1; end
            1: begin tick = TICK_W'(100000000); mask = '0; end
            2: begin tick = TICK_RESET; mask = MODE_RESET; end
            default: begin
               tick = TICK_W'($urandom_range(1, 100000000));
               mask = MODE_W'($urandom_range(0, 31));
            end
         endcase
         req_idle = (b != 3) && (b != 5);
         rsp_idle = (b != 3) && (b != 4);
         write_config(tick, mask);
         repeat (BURST_ITEMS) send_random_capture();
         drain_results();
      end

      repeat (48) @(posedge clock);
      if (meter.errors == 0 && meter.pending() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
